[hdl/integer_text_formatter_core_macros.svh]
// Assertion macros shared by the RTL.
`ifndef INTEGER_TEXT_FORMATTER_CORE_MACROS_SVH
`define INTEGER_TEXT_FORMATTER_CORE_MACROS_SVH
`ifndef ASSERT_OFF
// Check prop on every clock edge outside reset.
`define ITF_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
        else $error("integer_text_formatter_core: assertion failed");
// Check that cond implies conseq on the same edge.
`define ITF_ASSERT_IMPL(lbl, clk, rstn, cond, conseq) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |-> (conseq)) \
        else $error("integer_text_formatter_core: implication failed");
// Check that cond implies conseq on the next edge.
`define ITF_ASSERT_NEXT(lbl, clk, rstn, cond, conseq) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond) |=> (conseq)) \
        else $error("integer_text_formatter_core: next-cycle check failed");
`else
`define ITF_ASSERT(lbl, clk, rstn, prop)
`define ITF_ASSERT_IMPL(lbl, clk, rstn, cond, conseq)
`define ITF_ASSERT_NEXT(lbl, clk, rstn, cond, conseq)
`endif
`endif

[hdl/itf_pkg.sv]
package itf_pkg;

    // Configuration register indexes.
    localparam logic [2:0] REG_RADIX = 3'd0;
    localparam logic [2:0] REG_WIDTH = 3'd1;
    localparam logic [2:0] REG_FILL  = 3'd2;
    localparam logic [2:0] REG_ALIGN = 3'd3;
    localparam logic [2:0] REG_SIGN  = 3'd4;
    localparam logic [2:0] REG_ALT   = 3'd5;
    localparam logic [2:0] REG_ZPAD  = 3'd6;

    // Radix codes; the two unused codes format as decimal.
    localparam logic [2:0] RADIX_DEC    = 3'd0;
    localparam logic [2:0] RADIX_BIN    = 3'd1;
    localparam logic [2:0] RADIX_BIN_UC = 3'd2;
    localparam logic [2:0] RADIX_OCT    = 3'd3;
    localparam logic [2:0] RADIX_HEX    = 3'd4;
    localparam logic [2:0] RADIX_HEX_UC = 3'd5;

    // Alignment codes.
    localparam logic [1:0] ALIGN_DEFAULT = 2'd0;
    localparam logic [1:0] ALIGN_LEFT    = 2'd1;
    localparam logic [1:0] ALIGN_RIGHT   = 2'd2;
    localparam logic [1:0] ALIGN_CENTER  = 2'd3;

    // Sign codes; the unused code behaves as minus only.
    localparam logic [1:0] SIGN_MINUS    = 2'd0;
    localparam logic [1:0] SIGN_PLUS     = 2'd1;
    localparam logic [1:0] SIGN_SPACE    = 2'd2;
    localparam logic [1:0] SIGN_RESERVED = 2'd3;

    // Digit classes of the converter.
    localparam logic [1:0] CLS_DEC = 2'd0;
    localparam logic [1:0] CLS_BIN = 2'd1;
    localparam logic [1:0] CLS_OCT = 2'd2;
    localparam logic [1:0] CLS_HEX = 2'd3;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic        start;
        logic [1:0]  cls;
        logic        shift;
    } t_dig_cmd;

    typedef struct packed {
        logic        done;
        logic [6:0]  ndig;
        logic [3:0]  digit;
    } t_dig_stat;

    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
        logic [7:0] c;
        if (d < 4'd10) begin
            c = CH_ZERO + {4'd0, d};
        end else if (upper) begin
            c = 8'h37 + {4'd0, d};
        end else begin
            c = 8'h57 + {4'd0, d};
        end
        return c;
    endfunction

endpackage

[hdl/itf_digits.sv]
module itf_digits
    import itf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_dig_cmd    i_cmd,
    input  logic [63:0] i_mag,
    output t_dig_stat   o_stat
);

    localparam logic [1:0] D_IDLE = 2'd0;
    localparam logic [1:0] D_DAB  = 2'd1;
    localparam logic [1:0] D_NORM = 2'd2;
    localparam logic [1:0] D_RDY  = 2'd3;

    logic [1:0]  r_state, n_state;
    logic [79:0] r_w, n_w;
    logic [63:0] r_m, n_m;
    logic [6:0]  r_cnt, n_cnt;
    logic [6:0]  r_nd, n_nd;
    logic [1:0]  r_cls, n_cls;
    logic [79:0] w_adj;
    logic [79:0] w_shl;
    logic [3:0]  w_top;

    // Add three to every BCD digit of five or more before the shift.
    always_comb begin
        for (int k = 0; k < 20; k++) begin
            w_adj[k*4 +: 4] = (r_w[k*4 +: 4] >= 4'd5) ? r_w[k*4 +: 4] + 4'd3
                                                       : r_w[k*4 +: 4];
        end
    end

    always_comb begin
        case (r_cls)
            CLS_BIN: begin
                w_top = {3'd0, r_w[79]};
                w_shl = {r_w[78:0], 1'b0};
            end
            CLS_OCT: begin
                w_top = {1'b0, r_w[79:77]};
                w_shl = {r_w[76:0], 3'd0};
            end
            default: begin
                w_top = r_w[79:76];
                w_shl = {r_w[75:0], 4'd0};
            end
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_w     = r_w;
        n_m     = r_m;
        n_cnt   = r_cnt;
        n_nd    = r_nd;
        n_cls   = r_cls;
        unique case (r_state)
            D_DAB: begin
                n_w   = {w_adj[78:0], r_m[63]};
                n_m   = {r_m[62:0], 1'b0};
                n_cnt = r_cnt - 7'd1;
                if (r_cnt == 7'd1) begin
                    n_state = D_NORM;
                end
            end
            D_NORM: begin
                // Drop leading zero digits, keep at least one.
                if (w_top == 4'd0 && r_nd > 7'd1) begin
                    n_w  = w_shl;
                    n_nd = r_nd - 7'd1;
                end else begin
                    n_state = D_RDY;
                end
            end
            D_RDY: begin
                if (i_cmd.shift) begin
                    n_w = w_shl;
                end
            end
            default: ;
        endcase
        if (i_cmd.start) begin
            n_cls = i_cmd.cls;
            case (i_cmd.cls)
                CLS_DEC: begin
                    n_w     = '0;
                    n_m     = i_mag;
                    n_cnt   = 7'd64;
                    n_nd    = 7'd20;
                    n_state = D_DAB;
                end
                CLS_BIN: begin
                    n_w     = {i_mag, 16'd0};
                    n_nd    = 7'd64;
                    n_state = D_NORM;
                end
                CLS_OCT: begin
                    n_w     = {2'd0, i_mag, 14'd0};
                    n_nd    = 7'd22;
                    n_state = D_NORM;
                end
                default: begin
                    n_w     = {i_mag, 16'd0};
                    n_nd    = 7'd16;
                    n_state = D_NORM;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_w   <= n_w;
        r_m   <= n_m;
        r_cnt <= n_cnt;
        r_nd  <= n_nd;
        r_cls <= n_cls;
    end

    assign o_stat.done  = (r_state == D_RDY);
    assign o_stat.ndig  = r_nd;
    assign o_stat.digit = w_top;

endmodule

[hdl/integer_text_formatter_core.sv]
// Flow: decimal magnitudes run through double dabble (other radixes skip it), leading zero
// digits are dropped, the digits are seen and the text is planned, then the characters are
// placed one per cycle while the word is not full, skipping empty segments; each finished word
// passes through the output register.
// Throughput: one item at a time; the input stays blocked until the last character is placed.
// Reset (synchronous, active low) clears control and restores register defaults.
`include "integer_text_formatter_core_macros.svh"
module integer_text_formatter_core
    import itf_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [71:0] s_tdata,   // [63:0] magnitude, [64] negative, rest zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // [63:0] char_0..char_7, [67:64] char_count, rest zero
    output logic        m_tlast,   // last_word
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [7:0]  i_cfg_data
);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_CONV   = 4'd1;
    localparam logic [3:0] S_PLAN   = 4'd2;
    localparam logic [3:0] S_BEFORE = 4'd3;
    localparam logic [3:0] S_SIGN   = 4'd4;
    localparam logic [3:0] S_PFX    = 4'd5;
    localparam logic [3:0] S_ZERO   = 4'd6;
    localparam logic [3:0] S_DIG    = 4'd7;
    localparam logic [3:0] S_AFTER  = 4'd8;

    // Configuration registers.
    logic [2:0] r_radix;
    logic [6:0] r_width;
    logic [7:0] r_fill;
    logic [1:0] r_align;
    logic [1:0] r_sign_mode;
    logic       r_alt;
    logic       r_zpad;

    // Item control.
    logic [3:0] r_state, n_state;
    logic       r_neg, r_nz, r_upper;
    logic [1:0] r_cls;
    logic       r_sg, n_sg;
    logic [1:0] r_pl, n_pl;
    logic [7:0] r_pfx_ch;
    logic [6:0] r_before, n_before, r_zeros, n_zeros, r_after, n_after;
    logic [6:0] r_nd, n_nd, r_rem, n_rem;

    // Word assembly and output register.
    logic [7:0]  r_chars [8];
    logic [2:0]  r_pos;
    logic        r_wfull, r_wlast;
    logic [3:0]  r_wcnt;
    logic        r_ovalid, r_olast;
    logic [71:0] r_odata;

    t_dig_cmd   w_cmd;
    t_dig_stat  w_dig;
    logic       w_accept, w_emit, w_move, w_last;
    logic [7:0] w_ch;
    logic [1:0] w_cls;
    logic       w_sgn;
    logic [1:0] w_plen;
    logic [6:0] w_total, w_pad;
    logic       w_wide;

    assign s_tready = (r_state == S_IDLE);
    assign w_accept = s_tvalid && s_tready;
    assign w_last   = (r_rem == 7'd1);
    assign w_move   = r_wfull && (!r_ovalid || m_tready);

    always_comb begin
        case (r_radix) inside
            RADIX_BIN, RADIX_BIN_UC: w_cls = CLS_BIN;
            RADIX_OCT:               w_cls = CLS_OCT;
            RADIX_HEX, RADIX_HEX_UC: w_cls = CLS_HEX;
            default:                 w_cls = CLS_DEC;
        endcase
    end

    assign w_cmd.start = w_accept;
    assign w_cmd.cls   = w_cls;
    assign w_cmd.shift = w_emit && (r_state == S_DIG);

    itf_digits u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_cmd),
        .i_mag   (s_tdata[63:0]),
        .o_stat  (w_dig)
    );

    // Text length pieces: sign, prefix and digits.
    always_comb begin
        w_sgn = r_neg || (r_sign_mode == SIGN_PLUS) || (r_sign_mode == SIGN_SPACE);
        case (r_cls) inside
            CLS_BIN, CLS_HEX: w_plen = r_alt ? 2'd2 : 2'd0;
            CLS_OCT:          w_plen = (r_alt && r_nz) ? 2'd1 : 2'd0;
            default:          w_plen = 2'd0;
        endcase
        w_total = {6'd0, w_sgn} + {5'd0, w_plen} + w_dig.ndig;
        w_wide  = (r_width > w_total);
        w_pad   = w_wide ? r_width - w_total : 7'd0;
    end

    // One character per cycle while the word is not full; skip empty segments without emitting.
    always_comb begin
        n_state  = r_state;
        n_sg     = r_sg;
        n_pl     = r_pl;
        n_before = r_before;
        n_zeros  = r_zeros;
        n_after  = r_after;
        n_nd     = r_nd;
        n_rem    = r_rem;
        w_emit   = 1'b0;
        w_ch     = r_fill;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state = S_CONV;
                end
            end
            S_CONV: begin
                if (w_dig.done) begin
                    n_state = S_PLAN;
                end
            end
            S_PLAN: begin
                n_sg     = w_sgn;
                n_pl     = w_plen;
                n_nd     = w_dig.ndig;
                n_rem    = w_wide ? r_width : w_total;
                n_before = 7'd0;
                n_zeros  = 7'd0;
                n_after  = 7'd0;
                if (r_zpad && r_align == ALIGN_DEFAULT) begin
                    n_zeros = w_pad;
                end else if (r_align == ALIGN_LEFT) begin
                    n_after = w_pad;
                end else if (r_align == ALIGN_CENTER) begin
                    n_before = {1'b0, w_pad[6:1]};
                    n_after  = w_pad - {1'b0, w_pad[6:1]};
                end else begin
                    n_before = w_pad;
                end
                n_state = S_BEFORE;
            end
            S_BEFORE: begin
                if (r_before == 7'd0) begin
                    n_state = S_SIGN;
                end else if (!r_wfull) begin
                    w_emit   = 1'b1;
                    n_before = r_before - 7'd1;
                end
            end
            S_SIGN: begin
                w_ch = r_neg ? CH_MINUS : ((r_sign_mode == SIGN_PLUS) ? CH_PLUS : CH_SPACE);
                if (!r_sg) begin
                    n_state = S_PFX;
                end else if (!r_wfull) begin
                    w_emit = 1'b1;
                    n_sg   = 1'b0;
                end
            end
            S_PFX: begin
                w_ch = (r_pl == 2'd2) ? CH_ZERO : r_pfx_ch;
                if (r_pl == 2'd0) begin
                    n_state = S_ZERO;
                end else if (!r_wfull) begin
                    w_emit = 1'b1;
                    n_pl   = r_pl - 2'd1;
                end
            end
            S_ZERO: begin
                w_ch = CH_ZERO;
                if (r_zeros == 7'd0) begin
                    n_state = S_DIG;
                end else if (!r_wfull) begin
                    w_emit  = 1'b1;
                    n_zeros = r_zeros - 7'd1;
                end
            end
            S_DIG: begin
                w_ch = digit_char(w_dig.digit, r_upper);
                if (r_nd == 7'd0) begin
                    n_state = S_AFTER;
                end else if (!r_wfull) begin
                    w_emit = 1'b1;
                    n_nd   = r_nd - 7'd1;
                end
            end
            S_AFTER: begin
                if (!r_wfull && r_after != 7'd0) begin
                    w_emit  = 1'b1;
                    n_after = r_after - 7'd1;
                end
            end
            default: n_state = S_IDLE;
        endcase
        if (w_emit) begin
            n_rem = r_rem - 7'd1;
            if (w_last) begin
                n_state = S_IDLE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_radix     <= RADIX_DEC;
            r_width     <= 7'd0;
            r_fill      <= CH_SPACE;
            r_align     <= ALIGN_DEFAULT;
            r_sign_mode <= SIGN_MINUS;
            r_alt       <= 1'b0;
            r_zpad      <= 1'b0;
            r_pos       <= 3'd0;
            r_wfull     <= 1'b0;
            r_ovalid    <= 1'b0;
            for (int k = 0; k < 8; k++) begin
                r_chars[k] <= 8'd0;
            end
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_RADIX: r_radix     <= i_cfg_data[2:0];
                    REG_WIDTH: r_width     <= i_cfg_data[6:0];
                    REG_FILL:  r_fill      <= i_cfg_data;
                    REG_ALIGN: r_align     <= i_cfg_data[1:0];
                    REG_SIGN:  r_sign_mode <= i_cfg_data[1:0];
                    REG_ALT:   r_alt       <= i_cfg_data[0];
                    REG_ZPAD:  r_zpad      <= i_cfg_data[0];
                    default: ;
                endcase
            end
            // Assemble a word; hold it once full until the output register frees.
            if (w_emit) begin
                r_chars[r_pos] <= w_ch;
                if (r_pos == 3'd7 || w_last) begin
                    r_wfull <= 1'b1;
                    r_wcnt  <= {1'b0, r_pos} + 4'd1;
                    r_wlast <= w_last;
                    r_pos   <= 3'd0;
                end else begin
                    r_pos <= r_pos + 3'd1;
                end
            end
            // Advance the word to the output; clear slots for the next word.
            if (w_move) begin
                r_wfull  <= 1'b0;
                r_ovalid <= 1'b1;
                r_olast  <= r_wlast;
                r_odata  <= {4'd0, r_wcnt, r_chars[7], r_chars[6], r_chars[5], r_chars[4],
                             r_chars[3], r_chars[2], r_chars[1], r_chars[0]};
                for (int k = 0; k < 8; k++) begin
                    r_chars[k] <= 8'd0;
                end
            end else if (m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
        if (w_accept) begin
            r_neg    <= s_tdata[64];
            r_nz     <= |s_tdata[63:0];
            r_cls    <= w_cls;
            r_upper  <= (r_radix == RADIX_BIN_UC) || (r_radix == RADIX_HEX_UC);
            r_pfx_ch <= (r_radix == RADIX_BIN)    ? 8'h62 :
                        (r_radix == RADIX_BIN_UC) ? 8'h42 :
                        (r_radix == RADIX_HEX)    ? 8'h78 :
                        (r_radix == RADIX_HEX_UC) ? 8'h58 : CH_ZERO;
        end
        r_sg     <= n_sg;
        r_pl     <= n_pl;
        r_before <= n_before;
        r_zeros  <= n_zeros;
        r_after  <= n_after;
        r_nd     <= n_nd;
        r_rem    <= n_rem;
    end

    assign m_tvalid = r_ovalid;
    assign m_tdata  = r_odata;
    assign m_tlast  = r_olast;

    `ITF_ASSERT_IMPL(a_dig_ready, i_clk, i_rst_n, w_cmd.shift, w_dig.done)
    `ITF_ASSERT_IMPL(a_emit_budget, i_clk, i_rst_n, w_emit, r_rem != 7'd0 && !r_wfull)
    `ITF_ASSERT(a_word_count, i_clk, i_rst_n, !r_wfull || (r_wcnt != 4'd0 && r_wcnt <= 4'd8))
    `ITF_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, w_accept, !s_tready)

endmodule
